// ----- src/spf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants of the substring position finder
// Register indexes, ASCII case folding and the per-byte step record.
// ----------------------------------------------------------------------------
package spf_pkg;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// bytes of pattern held in the two pattern registers
	localparam int PAT_REG_BYTES = 16;

	// width of the pattern length register
	localparam int PLEN_REG_W = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIND_LAST = 3'd4;

	// ascii letter range and case offset
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET   = 8'h20;

	// what the cell row reports for one accepted byte
	typedef struct packed {
		logic hit;        // every active cell matched
		logic last;       // final byte of the text
		logic empty_pat;  // pattern length is zero
		logic find_last;  // report the last occurrence
	} step_t;

	// map A-Z to a-z, everything else unchanged
	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/spf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_cell: one position of the text window
// Holds one recent text byte, passes it on to the next cell on every
// request and compares the byte it takes in against its pattern byte.
// ----------------------------------------------------------------------------
module spf_cell (
	input  wire logic       clk,
	input  wire logic       shift_en,
	input  wire logic [7:0] din,
	output logic      [7:0] dout,
	input  wire logic [7:0] pat_byte,
	input  wire logic       fold,
	input  wire logic       active,
	output logic            match
);

	logic [7:0] byte_q;
	logic [7:0] t_cmp;
	logic [7:0] p_cmp;

	// window byte, newest enters at cell zero
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;

	// the byte landing here this cycle is the one to compare
	always_comb begin
		t_cmp = fold ? spf_pkg::lower_ascii(din) : din;
		p_cmp = fold ? spf_pkg::lower_ascii(pat_byte) : pat_byte;
		match = !active || (t_cmp == p_cmp);
	end

endmodule
`default_nettype wire

// ----- src/spf_track.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_track: position bookkeeping and result register
// Counts text bytes, records first and latest match starts and presents
// the result of a text on its final byte through an output register.
// ----------------------------------------------------------------------------
module spf_track #(
	parameter int POSITION_BITS = 16,
	parameter int LEN_W         = 5
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     step_en,
	input  wire spf_pkg::step_t           step,
	input  wire logic [LEN_W-1:0]         plen,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          in_ready,
	output logic [POSITION_BITS-1:0]      out_pos,
	output logic                          out_found,
	output logic                          out_too_long
);

	localparam int AW = POSITION_BITS + 1;
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	logic [POSITION_BITS-1:0] bytes_seen_q;
	logic                     overflow_q;
	logic [POSITION_BITS-1:0] first_q;
	logic [POSITION_BITS-1:0] latest_q;
	logic                     any_q;

	logic                     valid_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     found_q;
	logic                     too_long_q;

	logic                     sat;
	logic                     ovf_n;
	logic [AW-1:0]            avail;
	logic [AW-1:0]            plen_x;
	logic [POSITION_BITS-1:0] diff;
	logic                     hit_ok;
	logic [POSITION_BITS-1:0] start;
	logic                     any_n;
	logic [POSITION_BITS-1:0] first_n;
	logic [POSITION_BITS-1:0] latest_n;
	logic [POSITION_BITS-1:0] seen_n;
	logic [POSITION_BITS-1:0] res_pos;
	logic                     res_found;

	// a new request fits when the result slot is empty or draining
	assign in_ready = !valid_q || out_ready;

	// next bookkeeping values for this byte
	always_comb begin
		sat      = (bytes_seen_q == POS_MAX);
		ovf_n    = overflow_q || sat;
		avail    = {1'b0, bytes_seen_q} + AW'(1);
		plen_x   = AW'(plen);
		diff     = avail[POSITION_BITS-1:0] - plen_x[POSITION_BITS-1:0];
		hit_ok   = step.hit && !step.empty_pat && (avail >= plen_x);
		start    = sat ? POS_MAX : diff;
		any_n    = any_q || hit_ok;
		first_n  = (hit_ok && !any_q) ? start : first_q;
		latest_n = hit_ok ? start : latest_q;
		seen_n   = sat ? bytes_seen_q : bytes_seen_q + POSITION_BITS'(1);
		if (step.empty_pat) begin
			res_pos   = '0;
			res_found = 1'b1;
		end else if (any_n) begin
			res_pos   = step.find_last ? latest_n : first_n;
			res_found = 1'b1;
		end else begin
			res_pos   = seen_n;
			res_found = 1'b0;
		end
	end

	// per-text state, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			overflow_q   <= 1'b0;
			first_q      <= '0;
			latest_q     <= '0;
			any_q        <= 1'b0;
		end else if (step_en) begin
			if (step.last) begin
				bytes_seen_q <= '0;
				overflow_q   <= 1'b0;
				first_q      <= '0;
				latest_q     <= '0;
				any_q        <= 1'b0;
			end else begin
				bytes_seen_q <= seen_n;
				overflow_q   <= ovf_n;
				first_q      <= first_n;
				latest_q     <= latest_n;
				any_q        <= any_n;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step_en && step.last) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step_en && step.last) begin
			pos_q      <= res_pos;
			found_q    <= res_found;
			too_long_q <= ovf_n;
		end
	end

	assign out_valid    = valid_q;
	assign out_pos      = pos_q;
	assign out_found    = found_q;
	assign out_too_long = too_long_q;

endmodule
`default_nettype wire

// ----- src/substring_position_finder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// substring_position_finder_top: streaming first/last substring search
//
//   channel  direction  payload
//   s_axis   in         tdata = text_byte, tlast = end_of_text
//   m_axis   out        tdata = match_position, tuser = match_found, text_too_long
//   cfg      in         pattern low/high, pattern length, fold case, find last
//
// One text byte per cycle while s_axis_tready is high; every pattern position
// compares in its own cell of the window row, so the single register stage of
// the row sets the rate. The result of a text leaves from an output register in the
// cycle after its final byte is accepted. s_axis_tready drops only while a result
// waits and m_axis_tready is low. Reset clears all control state, not window or result data.
// ----------------------------------------------------------------------------
module substring_position_finder_top #(
	parameter int MAX_PATTERN   = 16,
	parameter int POSITION_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// text stream
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  wire logic [7:0]                           s_axis_tdata,  // [7:0] text_byte
	input  wire logic                                 s_axis_tlast,
	// result stream
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// match_position from bit 0, zero padded to whole bytes
	output logic [((POSITION_BITS+7)/8)*8-1:0]        m_axis_tdata,
	output logic [1:0]                                m_axis_tuser,  // [0] match_found, [1] text_too_long
	// configuration
	input  wire logic                                 cfg_we,
	input  wire logic [spf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [spf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	localparam int OUT_W  = ((POSITION_BITS + 7) / 8) * 8;
	localparam int LEN_C  = $clog2(MAX_PATTERN + 1);
	localparam int LEN_W  = (LEN_C > spf_pkg::PLEN_REG_W) ? LEN_C : spf_pkg::PLEN_REG_W;
	localparam int IDX_C  = $clog2(MAX_PATTERN);
	localparam int IDX_W  = (IDX_C > 1) ? IDX_C : 1;

	logic [spf_pkg::CFG_DATA_W-1:0] pat_low_q;
	logic [spf_pkg::CFG_DATA_W-1:0] pat_high_q;
	logic [spf_pkg::PLEN_REG_W-1:0] pat_len_q;
	logic                           fold_q;
	logic                           find_last_q;

	logic [2*spf_pkg::CFG_DATA_W-1:0] pat_all;
	logic [LEN_W-1:0]   plen_raw;
	logic [LEN_W-1:0]   plen;
	logic [7:0]         pat_bytes [MAX_PATTERN];
	logic [7:0]         chain     [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0] match;
	logic               in_accept;
	spf_pkg::step_t     step;
	logic [POSITION_BITS-1:0] out_pos;
	logic               out_found;
	logic               out_too_long;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q   <= '0;
			pat_high_q  <= '0;
			pat_len_q   <= '0;
			fold_q      <= 1'b0;
			find_last_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				spf_pkg::REG_PAT_LOW:   pat_low_q   <= cfg_wdata;
				spf_pkg::REG_PAT_HIGH:  pat_high_q  <= cfg_wdata;
				spf_pkg::REG_PAT_LEN:   pat_len_q   <= cfg_wdata[spf_pkg::PLEN_REG_W-1:0];
				spf_pkg::REG_FOLD_CASE: fold_q      <= cfg_wdata[0];
				spf_pkg::REG_FIND_LAST: find_last_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// pattern length limited to the window size
	always_comb begin
		plen_raw = LEN_W'(pat_len_q);
		plen     = (plen_raw > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_raw;
	end

	// both pattern registers as one byte string, byte 0 lowest
	assign pat_all = {pat_high_q, pat_low_q};

	// pattern bytes, zero beyond the register contents
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat
		if (j < spf_pkg::PAT_REG_BYTES) begin : g_reg
			assign pat_bytes[j] = pat_all[8*j +: 8];
		end else begin : g_zero
			assign pat_bytes[j] = 8'h00;
		end
	end

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign chain[0]  = s_axis_tdata;

	// window row: cell k holds the byte k places back
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [LEN_W-1:0] sel;
		logic             active;
		assign sel    = plen - LEN_W'(1) - LEN_W'(k);
		assign active = LEN_W'(k) < plen;

		spf_cell u_cell (
			.clk      (clk),
			.shift_en (in_accept),
			.din      (chain[k]),
			.dout     (chain[k+1]),
			.pat_byte (pat_bytes[sel[IDX_W-1:0]]),
			.fold     (fold_q),
			.active   (active),
			.match    (match[k])
		);
	end

	// step record for the bookkeeping
	always_comb begin
		step.hit       = &match;
		step.last      = s_axis_tlast;
		step.empty_pat = (plen == '0);
		step.find_last = find_last_q;
	end

	spf_track #(
		.POSITION_BITS (POSITION_BITS),
		.LEN_W         (LEN_W)
	) u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (in_accept),
		.step         (step),
		.plen         (plen),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.in_ready     (s_axis_tready),
		.out_pos      (out_pos),
		.out_found    (out_found),
		.out_too_long (out_too_long)
	);

	// result packing
	assign m_axis_tdata = OUT_W'(out_pos);
	assign m_axis_tuser = {out_too_long, out_found};

endmodule
`default_nettype wire
